### hdl/vqdfl_pkg.sv
// Package for the virtqueue descriptor free list: sizes, codes and the
// word types shared by the sequencer and the top level. No dependencies.
package vqdfl_pkg;

    localparam int MAX_QUEUE = 256;
    localparam int IDX_W     = $clog2(MAX_QUEUE);
    localparam int TOT_W     = $clog2(MAX_QUEUE + 1);
    localparam int REM_W     = (TOT_W > 9) ? TOT_W : 9;
    localparam int CMP_W     = ((TOT_W > 16) ? TOT_W : 16) + 1;
    localparam int RAM_W     = 64 + 32 + 16 + 16;

    localparam logic [TOT_W-1:0] QS_RESET =
        TOT_W'((MAX_QUEUE < 256) ? MAX_QUEUE : 256);
    localparam logic [15:0] NO_CHAIN = 16'hFFFF;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [8:0]  count;
        logic [15:0] index;
        logic [63:0] buf_addr;
        logic [31:0] buf_len;
        logic [15:0] buf_flags;
        logic [15:0] link_index;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] head_index;
        logic [8:0]  free_count;
        logic [63:0] desc_addr;
        logic [31:0] desc_len;
        logic [15:0] desc_flags;
        logic [15:0] desc_link;
    } t_result;

    typedef struct packed {
        logic             load;
        logic [TOT_W-1:0] size;
    } t_cfg;

endpackage

### hdl/virtqueue_descriptor_free_list_top.sv
// Top level of the virtqueue descriptor free list: stream ports, queue size
// register and result register. Depends on vqdfl_pkg, vqdfl_seq.
//
// One word in gives one word out. The block takes a word only when the
// sequencer is idle; the result then sits in an output register so the next
// word can be taken while it waits. Set and rejected words go straight to
// the result; a read does one registered table read; alloc and free walk
// the chain, each link costing one registered read of the single table RAM
// and one update state. Writing the queue size resets head and count and
// marks every entry as rebuilt at once; no clearing pass is needed.
module virtqueue_descriptor_free_list_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [8:0]   i_cfg_wr_data,   // table size
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // count[8:0], index[24:9], buf_addr[88:25], buf_len[120:89],
    // buf_flags[136:121], link_index[152:137], zero pad
    input  logic [159:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,    // action[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], head_index[17:2], free_count[26:18], desc_addr[90:27],
    // desc_len[122:91], desc_flags[138:123], desc_link[154:139], zero pad
    output logic [159:0] m_axis_tdata
);
    import vqdfl_pkg::*;

    logic [TOT_W-1:0] r_qs, n_qs;
    logic             r_out_valid;
    t_result          r_out;
    t_cfg             cfg;
    t_item            item;
    t_result          res;
    logic             res_valid, res_ready, seq_ready;

    always_comb begin
        if (i_cfg_wr_data == 9'd0) begin
            n_qs = TOT_W'(1);
        end else if (32'(i_cfg_wr_data) > 32'(MAX_QUEUE)) begin
            n_qs = TOT_W'(MAX_QUEUE);
        end else begin
            n_qs = TOT_W'(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qs <= QS_RESET;
        end else if (i_cfg_wr_en) begin
            r_qs <= n_qs;
        end
    end

    assign cfg = '{load: i_cfg_wr_en, size: (i_cfg_wr_en ? n_qs : r_qs)};

    assign item = '{action:     s_axis_tuser,
                    count:      s_axis_tdata[8:0],
                    index:      s_axis_tdata[24:9],
                    buf_addr:   s_axis_tdata[88:25],
                    buf_len:    s_axis_tdata[120:89],
                    buf_flags:  s_axis_tdata[136:121],
                    link_index: s_axis_tdata[152:137]};

    vqdfl_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_start     (s_axis_tvalid),
        .i_item      (item),
        .o_ready     (seq_ready),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign s_axis_tready = seq_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.desc_link, r_out.desc_flags, r_out.desc_len,
                            r_out.desc_addr, r_out.free_count, r_out.head_index,
                            r_out.status};

endmodule

### hdl/vqdfl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module vqdfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/vqdfl_seq.sv
// Sequencer for the descriptor table: walks alloc and free chains one link
// at a time over the shared range compare. Depends on vqdfl_pkg, vqdfl_ram.
module vqdfl_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vqdfl_pkg::t_cfg   i_cfg,
    input  logic              i_start,
    input  vqdfl_pkg::t_item  i_item,
    output logic              o_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output vqdfl_pkg::t_result o_res
);
    import vqdfl_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ALLOC_RD = 3'd1;
    localparam logic [2:0] S_ALLOC_NX = 3'd2;
    localparam logic [2:0] S_FREE_RD  = 3'd3;
    localparam logic [2:0] S_FREE_WR  = 3'd4;
    localparam logic [2:0] S_READ_RD  = 3'd5;
    localparam logic [2:0] S_READ_WT  = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_free_head, n_free_head;
    logic [TOT_W-1:0]     r_free_total, n_free_total;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [IDX_W-1:0]     r_cur, n_cur;
    logic [TOT_W-1:0]     r_steps, n_steps;
    logic [1:0]           r_status, n_status;
    logic [15:0]          r_head, n_head;
    logic [63:0]          r_daddr, n_daddr;
    logic [31:0]          r_dlen, n_dlen;
    logic [15:0]          r_dflags, n_dflags;
    logic [15:0]          r_dlink, n_dlink;
    logic [MAX_QUEUE-1:0] r_valid;
    logic                 r_rd_valid;
    logic [IDX_W-1:0]     r_rd_addr;

    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [RAM_W-1:0] wr_data, ram_q;
    logic [63:0]      eff_addr;
    logic [31:0]      eff_len;
    logic [15:0]      eff_flags, eff_link, rst_link, cmp_val;
    logic [IDX_W:0]   rst_nxt;
    logic             cmp_lt;
    logic [TOT_W-1:0] steps_inc;

    vqdfl_ram #(.WIDTH(RAM_W), .DEPTH(MAX_QUEUE)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // entry never written since rebuild reads as its rebuilt value
    assign rst_nxt  = (IDX_W+1)'(r_rd_addr) + 1'b1;
    assign rst_link = (CMP_W'(rst_nxt) < CMP_W'(i_cfg.size)) ? 16'(rst_nxt) : 16'd0;
    assign eff_addr  = r_rd_valid ? ram_q[63:0]    : 64'd0;
    assign eff_len   = r_rd_valid ? ram_q[95:64]   : 32'd0;
    assign eff_flags = r_rd_valid ? ram_q[111:96]  : 16'd0;
    assign eff_link  = r_rd_valid ? ram_q[127:112] : rst_link;

    // shared range compare
    assign cmp_val = (r_state == S_IDLE) ? i_item.index : eff_link;
    assign cmp_lt  = CMP_W'(cmp_val) < CMP_W'(i_cfg.size);

    assign steps_inc = r_steps + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_free_total = r_free_total;
        n_rem        = r_rem;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_status     = r_status;
        n_head       = r_head;
        n_daddr      = r_daddr;
        n_dlen       = r_dlen;
        n_dflags     = r_dflags;
        n_dlink      = r_dlink;
        rd_en        = 1'b0;
        rd_addr      = r_cur;
        wr_en        = 1'b0;
        wr_addr      = r_cur;
        wr_data      = {16'(r_free_head), 16'd0, 32'd0, 64'd0};
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_OK;
                    n_head   = NO_CHAIN;
                    n_daddr  = '0;
                    n_dlen   = '0;
                    n_dflags = '0;
                    n_dlink  = '0;
                    n_cur    = i_item.index[IDX_W-1:0];
                    n_steps  = '0;
                    n_rem    = REM_W'(i_item.count);
                    if (i_item.action == ACT_ALLOC) begin
                        if (i_item.count == 9'd0 ||
                            REM_W'(i_item.count) > REM_W'(r_free_total)) begin
                            n_status = ST_BAD_COUNT;
                            n_state  = S_DONE;
                        end else begin
                            n_head  = 16'(r_free_head);
                            n_state = S_ALLOC_RD;
                        end
                    end else if (!cmp_lt) begin
                        n_status = ST_BAD_INDEX;
                        n_state  = S_DONE;
                    end else if (i_item.action == ACT_SET) begin
                        wr_en   = 1'b1;
                        wr_addr = i_item.index[IDX_W-1:0];
                        wr_data = {i_item.link_index, i_item.buf_flags,
                                   i_item.buf_len, i_item.buf_addr};
                        n_state = S_DONE;
                    end else if (i_item.action == ACT_FREE) begin
                        n_state = S_FREE_RD;
                    end else begin
                        n_state = S_READ_RD;
                    end
                end
            end
            S_ALLOC_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_free_head;
                n_state = S_ALLOC_NX;
            end
            S_ALLOC_NX: begin
                n_free_head  = cmp_lt ? eff_link[IDX_W-1:0] : '0;
                n_free_total = r_free_total - 1'b1;
                n_rem        = r_rem - 1'b1;
                n_state      = (r_rem == REM_W'(1)) ? S_DONE : S_ALLOC_RD;
            end
            S_FREE_RD: begin
                rd_en   = 1'b1;
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                wr_en       = 1'b1;
                n_free_head = r_cur;
                if (r_free_total < i_cfg.size) begin
                    n_free_total = r_free_total + 1'b1;
                end
                n_steps = steps_inc;
                if (!eff_flags[0] || !cmp_lt || steps_inc == i_cfg.size) begin
                    n_state = S_DONE;
                end else begin
                    n_cur   = eff_link[IDX_W-1:0];
                    n_state = S_FREE_RD;
                end
            end
            S_READ_RD: begin
                rd_en   = 1'b1;
                n_state = S_READ_WT;
            end
            S_READ_WT: begin
                n_daddr  = eff_addr;
                n_dlen   = eff_len;
                n_dflags = eff_flags;
                n_dlink  = eff_link;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_free_total <= QS_RESET;
            r_valid      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.load) begin
                r_free_head  <= '0;
                r_free_total <= i_cfg.size;
                r_valid      <= '0;
            end else begin
                r_free_head  <= n_free_head;
                r_free_total <= n_free_total;
                if (wr_en) begin
                    r_valid[wr_addr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_cur    <= n_cur;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_head   <= n_head;
        r_daddr  <= n_daddr;
        r_dlen   <= n_dlen;
        r_dflags <= n_dflags;
        r_dlink  <= n_dlink;
        if (rd_en) begin
            r_rd_valid <= r_valid[rd_addr];
            r_rd_addr  <= rd_addr;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res = '{status:     r_status,
                     head_index: r_head,
                     free_count: 9'(r_free_total),
                     desc_addr:  r_daddr,
                     desc_len:   r_dlen,
                     desc_flags: r_dflags,
                     desc_link:  r_dlink};

    a_total_le_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.load || (r_free_total <= i_cfg.size))
        else $error("free total above queue size");

    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.load || (CMP_W'(r_free_head) < CMP_W'(i_cfg.size)))
        else $error("free head out of range");

    a_alloc_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC_NX) |-> (r_rem != '0) && (r_free_total != '0))
        else $error("alloc walk past its count");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && !i_res_ready |=> (r_state == S_DONE))
        else $error("result dropped");

    a_no_wr_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("read and write in one cycle");

endmodule
